### design/lvm_pkg.sv
// lookat view matrix package: widths, pipeline depths, row codes and rounding helper
`timescale 1ns / 1ps
`default_nettype none
package lvm_pkg;

	localparam int DW     = 32;
	localparam int FRAC   = 16;
	localparam int UW     = 18;
	localparam int UUW    = 20;
	localparam int AW     = 30;
	localparam int SRW    = 31;
	localparam int RADW   = 62;
	localparam int NSQ    = 31;
	localparam int SQ_PER = 2;
	localparam int SQ_ST  = (NSQ + SQ_PER - 1) / SQ_PER;
	localparam int DQ     = 17;
	localparam int DV_PER = 2;
	localparam int DV_ST  = (DQ + DV_PER - 1) / DV_PER;
	localparam int NUM_W  = AW + FRAC + 1;
	localparam int NORM_ST = 6 + SQ_ST + 1 + DV_ST + 1;
	localparam int DPW    = 54;

	localparam logic signed [DW-1:0] Q_ONE = 32'sd65536;

	typedef enum logic [1:0] {
		ROW_RIGHT,
		ROW_UP,
		ROW_FWD,
		ROW_W
	} row_t;

	// q22.32 to q16.16, nearest with halves up, then clamp to 32 bits
	function automatic logic signed [DW-1:0] rnd_sat(input logic signed [DPW-1:0] x);
		logic signed [DPW-1:0] t;
		t = (x + DPW'(32768)) >>> FRAC;
		if (t > DPW'(2147483647))
			return 32'sh7fffffff;
		else if (t < -DPW'(64'sd2147483648))
			return 32'sh80000000;
		else
			return DW'(t);
	endfunction

endpackage
`default_nettype wire

### design/lvm_norm.sv
// lookat view matrix vector normalizer: scale, sum of squares, square root, divide
`timescale 1ns / 1ps
`default_nettype none
module lvm_norm #(
	parameter int VW = 33,
	parameter int SW = 8
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         en,
	input  wire logic                         in_vld,
	input  wire logic signed [VW-1:0]         v_x,
	input  wire logic signed [VW-1:0]         v_y,
	input  wire logic signed [VW-1:0]         v_z,
	input  wire logic [SW-1:0]                side_in,
	output logic                              out_vld,
	output logic                              out_ok,
	output logic signed [lvm_pkg::UW-1:0]     o_x,
	output logic signed [lvm_pkg::UW-1:0]     o_y,
	output logic signed [lvm_pkg::UW-1:0]     o_z,
	output logic [SW-1:0]                     side_out
);
	import lvm_pkg::*;

	localparam int BLW = $clog2(VW + 1);
	localparam int RW  = SRW + 2;

	logic signed [VW-1:0] v [3];
	assign v[0] = v_x;
	assign v[1] = v_y;
	assign v[2] = v_z;

	logic          vld_q  [NORM_ST];
	logic          ok_q   [NORM_ST];
	logic [2:0]    neg_q  [NORM_ST];
	logic [SW-1:0] side_q [NORM_ST];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < NORM_ST; j++)
				vld_q[j] <= 1'b0;
		end else if (en) begin
			vld_q[0] <= in_vld;
			for (int j = 1; j < NORM_ST; j++)
				vld_q[j] <= vld_q[j-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ok_q[0]   <= (v_x != '0) || (v_y != '0) || (v_z != '0);
			neg_q[0]  <= {v_z[VW-1], v_y[VW-1], v_x[VW-1]};
			side_q[0] <= side_in;
			for (int j = 1; j < NORM_ST; j++) begin
				ok_q[j]   <= ok_q[j-1];
				neg_q[j]  <= neg_q[j-1];
				side_q[j] <= side_q[j-1];
			end
		end
	end

	// magnitudes
	logic [VW-1:0] a_s1 [3];
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++)
				a_s1[i] <= v[i][VW-1] ? VW'(-v[i]) : VW'(v[i]);
		end
	end

	// largest magnitude
	logic [VW-1:0] m_c;
	logic [VW-1:0] m_s2;
	logic [VW-1:0] a_s2 [3];
	always_comb begin
		m_c = a_s1[0];
		if (a_s1[1] > m_c)
			m_c = a_s1[1];
		if (a_s1[2] > m_c)
			m_c = a_s1[2];
	end
	always_ff @(posedge clk) begin
		if (en) begin
			m_s2 <= m_c;
			a_s2 <= a_s1;
		end
	end

	// bit length of the largest magnitude
	logic [BLW-1:0] bl_c;
	logic [BLW-1:0] bl_s3;
	logic [VW-1:0]  a_s3 [3];
	always_comb begin
		bl_c = '0;
		for (int i = 0; i < VW; i++)
			if (m_s2[i])
				bl_c = BLW'(i + 1);
	end
	always_ff @(posedge clk) begin
		if (en) begin
			bl_s3 <= bl_c;
			a_s3  <= a_s2;
		end
	end

	// scale so the largest lands in [2^29, 2^30)
	logic [AW-1:0] n_c [3];
	logic [AW-1:0] n_s4 [3];
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (int'(bl_s3) > AW)
				n_c[i] = AW'(a_s3[i] >> (int'(bl_s3) - AW));
			else
				n_c[i] = AW'({{AW{1'b0}}, a_s3[i]} << (AW - int'(bl_s3)));
		end
	end
	always_ff @(posedge clk) begin
		if (en)
			n_s4 <= n_c;
	end

	logic [2*AW-1:0] sq_s5 [3];
	logic [AW-1:0]   n_s5 [3];
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++)
				sq_s5[i] <= n_s4[i] * n_s4[i];
			n_s5 <= n_s4;
		end
	end

	logic [RADW-1:0] sum_s6;
	logic [AW-1:0]   n_s6 [3];
	always_ff @(posedge clk) begin
		if (en) begin
			sum_s6 <= RADW'(sq_s5[0]) + RADW'(sq_s5[1]) + RADW'(sq_s5[2]);
			n_s6   <= n_s5;
		end
	end

	// square root, two result bits per stage
	logic [RW-1:0]   sr_q [SQ_ST];
	logic [SRW-1:0]  sq_q [SQ_ST];
	logic [RADW-1:0] sn_q [SQ_ST];
	logic [AW-1:0]   sa_q [SQ_ST][3];

	for (genvar k = 0; k < SQ_ST; k++) begin : g_sq
		logic [RW-1:0]   r_in;
		logic [SRW-1:0]  q_in;
		logic [RADW-1:0] n_in;
		logic [AW-1:0]   a_in [3];
		logic [RW-1:0]   r_c;
		logic [SRW-1:0]  q_c;
		logic [RADW-1:0] rn_c;

		if (k == 0) begin : g_first
			assign r_in = '0;
			assign q_in = '0;
			assign n_in = sum_s6;
			assign a_in = n_s6;
		end else begin : g_next
			assign r_in = sr_q[k-1];
			assign q_in = sq_q[k-1];
			assign n_in = sn_q[k-1];
			assign a_in = sa_q[k-1];
		end

		always_comb begin
			logic [RW+1:0] r2;
			logic [RW+1:0] t;
			r2   = '0;
			t    = '0;
			r_c  = r_in;
			q_c  = q_in;
			rn_c = n_in;
			for (int j = 0; j < SQ_PER; j++) begin
				if (k * SQ_PER + j < NSQ) begin
					r2 = {r_c, rn_c[RADW-1 -: 2]};
					t  = (RW + 2)'({q_c, 2'b01});
					if (r2 >= t) begin
						r2  = r2 - t;
						q_c = {q_c[SRW-2:0], 1'b1};
					end else begin
						q_c = {q_c[SRW-2:0], 1'b0};
					end
					r_c  = r2[RW-1:0];
					rn_c = {rn_c[RADW-3:0], 2'b00};
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sr_q[k] <= r_c;
				sq_q[k] <= q_c;
				sn_q[k] <= rn_c;
				sa_q[k] <= a_in;
			end
		end
	end

	// dividend set up with half the divisor for rounding
	logic [SRW-1:0]   mag_s7;
	logic [SRW-1:0]   dr_s7 [3];
	logic [DQ-1:0]    dl_s7 [3];
	always_ff @(posedge clk) begin
		logic [NUM_W-1:0] num;
		if (en) begin
			mag_s7 <= sq_q[SQ_ST-1];
			for (int i = 0; i < 3; i++) begin
				num = NUM_W'({sa_q[SQ_ST-1][i], {FRAC{1'b0}}})
					+ NUM_W'(sq_q[SQ_ST-1] >> 1);
				dr_s7[i] <= SRW'(num[NUM_W-1:DQ]);
				dl_s7[i] <= num[DQ-1:0];
			end
		end
	end

	// restoring divide, two quotient bits per stage
	logic [SRW-1:0] dm_q [DV_ST];
	logic [SRW-1:0] dr_q [DV_ST][3];
	logic [DQ-1:0]  dl_q [DV_ST][3];
	logic [DQ-1:0]  dq_q [DV_ST][3];

	for (genvar k = 0; k < DV_ST; k++) begin : g_dv
		logic [SRW-1:0] m_in;
		logic [SRW-1:0] r_in [3];
		logic [DQ-1:0]  l_in [3];
		logic [DQ-1:0]  q_in [3];
		logic [SRW-1:0] r_c [3];
		logic [DQ-1:0]  l_c [3];
		logic [DQ-1:0]  q_c [3];

		if (k == 0) begin : g_first
			assign m_in = mag_s7;
			assign r_in = dr_s7;
			assign l_in = dl_s7;
			assign q_in = '{default: '0};
		end else begin : g_next
			assign m_in = dm_q[k-1];
			assign r_in = dr_q[k-1];
			assign l_in = dl_q[k-1];
			assign q_in = dq_q[k-1];
		end

		always_comb begin
			logic [SRW:0] r2;
			r2 = '0;
			for (int i = 0; i < 3; i++) begin
				r_c[i] = r_in[i];
				l_c[i] = l_in[i];
				q_c[i] = q_in[i];
				for (int j = 0; j < DV_PER; j++) begin
					if (k * DV_PER + j < DQ) begin
						r2 = {r_c[i], l_c[i][DQ-1]};
						if (r2 >= {1'b0, m_in}) begin
							r2     = r2 - {1'b0, m_in};
							q_c[i] = {q_c[i][DQ-2:0], 1'b1};
						end else begin
							q_c[i] = {q_c[i][DQ-2:0], 1'b0};
						end
						r_c[i] = r2[SRW-1:0];
						l_c[i] = {l_c[i][DQ-2:0], 1'b0};
					end
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dm_q[k] <= m_in;
				dr_q[k] <= r_c;
				dl_q[k] <= l_c;
				dq_q[k] <= q_c;
			end
		end
	end

	// signs back on
	logic signed [UW-1:0] o_s [3];
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++)
				o_s[i] <= neg_q[NORM_ST-2][i] ? -UW'({1'b0, dq_q[DV_ST-1][i]})
					: UW'({1'b0, dq_q[DV_ST-1][i]});
		end
	end

	assign o_x      = o_s[0];
	assign o_y      = o_s[1];
	assign o_z      = o_s[2];
	assign out_vld  = vld_q[NORM_ST-1];
	assign out_ok   = ok_q[NORM_ST-1];
	assign side_out = side_q[NORM_ST-1];

endmodule
`default_nettype wire

### design/lookat_view_matrix.sv
// lookat view matrix top level: builds the 4x4 view matrix and sends it one row at a time
//
// Input channel: in_valid / in_stall with camera position, target and up vector (q16.16).
// Output channel: out_valid / out_stall, one matrix row per transfer, row_index 0..3,
// last set on row 3, degenerate repeated on all four rows.
// Each request passes a 74-stage pipeline: two normalizers (square root and divide
// stages, two bits per stage), the cross products and the dot products. The first
// row is shown once the request has left the pipeline and been loaded into the
// output matrix register; the next three rows follow as the receiver takes them.
// Sustained throughput is bound by the four rows each request sends through the
// single output port; the pipeline takes a request in any cycle in which in_stall
// is low, that is, while its final stage is empty or hands over to the output register.
// Reset clears all valid bits and the row counter; nothing else needs clearing.
// When the receiver stalls, the row being shown holds, the pipeline freezes once
// its final stage is waiting, and in_stall rises; no request is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none
module lookat_view_matrix (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic signed [lvm_pkg::DW-1:0] pos_x,
	input  wire logic signed [lvm_pkg::DW-1:0] pos_y,
	input  wire logic signed [lvm_pkg::DW-1:0] pos_z,
	input  wire logic signed [lvm_pkg::DW-1:0] target_x,
	input  wire logic signed [lvm_pkg::DW-1:0] target_y,
	input  wire logic signed [lvm_pkg::DW-1:0] target_z,
	input  wire logic signed [lvm_pkg::DW-1:0] up_x,
	input  wire logic signed [lvm_pkg::DW-1:0] up_y,
	input  wire logic signed [lvm_pkg::DW-1:0] up_z,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic [1:0]                        row_index,
	output logic signed [lvm_pkg::DW-1:0]     col0,
	output logic signed [lvm_pkg::DW-1:0]     col1,
	output logic signed [lvm_pkg::DW-1:0]     col2,
	output logic signed [lvm_pkg::DW-1:0]     col3,
	output logic                              degenerate,
	output logic                              last
);
	import lvm_pkg::*;

	localparam int S1W = 6 * DW;
	localparam int S2W = 1 + 3 * UW + 3 * DW;
	localparam int XPW = UW + DW;
	localparam int CW  = XPW + 1;
	localparam int SFW = 2 * UW;
	localparam int SPW = UW + DW;
	localparam int SUW = SPW + 2;
	localparam int UPW = UUW + DW;

	logic en;
	logic load;
	logic vld_p5;

	// input stage
	logic                 vld_s1;
	logic signed [DW-1:0] p_s1  [3];
	logic signed [DW-1:0] up_s1 [3];
	logic signed [DW:0]   d_s1  [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (en)
			vld_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1  <= '{pos_x, pos_y, pos_z};
			up_s1 <= '{up_x, up_y, up_z};
			d_s1[0] <= (DW + 1)'(target_x) - (DW + 1)'(pos_x);
			d_s1[1] <= (DW + 1)'(target_y) - (DW + 1)'(pos_y);
			d_s1[2] <= (DW + 1)'(target_z) - (DW + 1)'(pos_z);
		end
	end

	// forward
	logic                 vld_n1;
	logic                 ok_n1;
	logic signed [UW-1:0] f_n1 [3];
	logic [S1W-1:0]       side_n1;
	logic signed [DW-1:0] p_n1  [3];
	logic signed [DW-1:0] up_n1 [3];

	lvm_norm #(
		.VW(DW + 1),
		.SW(S1W)
	) u_norm_fwd (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (vld_s1),
		.v_x     (d_s1[0]),
		.v_y     (d_s1[1]),
		.v_z     (d_s1[2]),
		.side_in ({p_s1[2], p_s1[1], p_s1[0], up_s1[2], up_s1[1], up_s1[0]}),
		.out_vld (vld_n1),
		.out_ok  (ok_n1),
		.o_x     (f_n1[0]),
		.o_y     (f_n1[1]),
		.o_z     (f_n1[2]),
		.side_out(side_n1)
	);

	assign {p_n1[2], p_n1[1], p_n1[0], up_n1[2], up_n1[1], up_n1[0]} = side_n1;

	// forward x up
	logic                  vld_x1;
	logic                  ok_x1;
	logic signed [UW-1:0]  f_x1 [3];
	logic signed [DW-1:0]  p_x1 [3];
	logic signed [XPW-1:0] xp_x1 [6];

	always_ff @(posedge clk) begin
		if (en) begin
			xp_x1[0] <= f_n1[1] * up_n1[2];
			xp_x1[1] <= f_n1[2] * up_n1[1];
			xp_x1[2] <= f_n1[2] * up_n1[0];
			xp_x1[3] <= f_n1[0] * up_n1[2];
			xp_x1[4] <= f_n1[0] * up_n1[1];
			xp_x1[5] <= f_n1[1] * up_n1[0];
			ok_x1 <= ok_n1;
			f_x1  <= f_n1;
			p_x1  <= p_n1;
		end
	end

	logic                 vld_x2;
	logic                 ok_x2;
	logic signed [UW-1:0] f_x2 [3];
	logic signed [DW-1:0] p_x2 [3];
	logic signed [CW-1:0] c_x2 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++)
				c_x2[i] <= CW'(xp_x1[2*i]) - CW'(xp_x1[2*i+1]);
			ok_x2 <= ok_x1;
			f_x2  <= f_x1;
			p_x2  <= p_x1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_x1 <= 1'b0;
			vld_x2 <= 1'b0;
		end else if (en) begin
			vld_x1 <= vld_n1;
			vld_x2 <= vld_x1;
		end
	end

	// right
	logic                 vld_n2;
	logic                 ok_n2;
	logic signed [UW-1:0] s_n2 [3];
	logic [S2W-1:0]       side_n2;
	logic                 ok1_n2;
	logic signed [UW-1:0] f_n2 [3];
	logic signed [DW-1:0] p_n2 [3];

	lvm_norm #(
		.VW(CW),
		.SW(S2W)
	) u_norm_right (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (vld_x2),
		.v_x     (c_x2[0]),
		.v_y     (c_x2[1]),
		.v_z     (c_x2[2]),
		.side_in ({ok_x2, f_x2[2], f_x2[1], f_x2[0], p_x2[2], p_x2[1], p_x2[0]}),
		.out_vld (vld_n2),
		.out_ok  (ok_n2),
		.o_x     (s_n2[0]),
		.o_y     (s_n2[1]),
		.o_z     (s_n2[2]),
		.side_out(side_n2)
	);

	assign {ok1_n2, f_n2[2], f_n2[1], f_n2[0], p_n2[2], p_n2[1], p_n2[0]} = side_n2;

	// products for true up and the translations
	logic                  vld_p1;
	logic                  dg_p1;
	logic signed [UW-1:0]  s_p1 [3];
	logic signed [UW-1:0]  f_p1 [3];
	logic signed [DW-1:0]  p_p1 [3];
	logic signed [SFW-1:0] sf_p1 [6];
	logic signed [SPW-1:0] sp_p1 [3];
	logic signed [SPW-1:0] fp_p1 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			sf_p1[0] <= s_n2[1] * f_n2[2];
			sf_p1[1] <= s_n2[2] * f_n2[1];
			sf_p1[2] <= s_n2[2] * f_n2[0];
			sf_p1[3] <= s_n2[0] * f_n2[2];
			sf_p1[4] <= s_n2[0] * f_n2[1];
			sf_p1[5] <= s_n2[1] * f_n2[0];
			for (int i = 0; i < 3; i++) begin
				sp_p1[i] <= s_n2[i] * p_n2[i];
				fp_p1[i] <= f_n2[i] * p_n2[i];
			end
			dg_p1 <= !(ok_n2 && ok1_n2);
			s_p1  <= s_n2;
			f_p1  <= f_n2;
			p_p1  <= p_n2;
		end
	end

	logic                  dg_p2;
	logic signed [UW-1:0]  s_p2 [3];
	logic signed [UW-1:0]  f_p2 [3];
	logic signed [DW-1:0]  p_p2 [3];
	logic signed [UUW-1:0] u_p2 [3];
	logic signed [SUW-1:0] tsn_p2;
	logic signed [SUW-1:0] fs_p2;

	always_ff @(posedge clk) begin
		logic signed [SFW:0] df;
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				df = (SFW + 1)'(sf_p1[2*i]) - (SFW + 1)'(sf_p1[2*i+1]);
				u_p2[i] <= UUW'((df + (SFW + 1)'(32768)) >>> FRAC);
			end
			tsn_p2 <= -(SUW'(sp_p1[0]) + SUW'(sp_p1[1]) + SUW'(sp_p1[2]));
			fs_p2  <= SUW'(fp_p1[0]) + SUW'(fp_p1[1]) + SUW'(fp_p1[2]);
			dg_p2  <= dg_p1;
			s_p2   <= s_p1;
			f_p2   <= f_p1;
			p_p2   <= p_p1;
		end
	end

	logic                  dg_p3;
	logic signed [UW-1:0]  s_p3 [3];
	logic signed [UW-1:0]  f_p3 [3];
	logic signed [UUW-1:0] u_p3 [3];
	logic signed [UPW-1:0] up_p3 [3];
	logic signed [DW-1:0]  ts_p3;
	logic signed [DW-1:0]  tf_p3;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++)
				up_p3[i] <= u_p2[i] * p_p2[i];
			ts_p3 <= rnd_sat(DPW'(tsn_p2));
			tf_p3 <= rnd_sat(DPW'(fs_p2));
			dg_p3 <= dg_p2;
			s_p3  <= s_p2;
			f_p3  <= f_p2;
			u_p3  <= u_p2;
		end
	end

	logic                  dg_p4;
	logic signed [UW-1:0]  s_p4 [3];
	logic signed [UW-1:0]  f_p4 [3];
	logic signed [UUW-1:0] u_p4 [3];
	logic signed [DPW-1:0] tun_p4;
	logic signed [DW-1:0]  ts_p4;
	logic signed [DW-1:0]  tf_p4;

	always_ff @(posedge clk) begin
		if (en) begin
			tun_p4 <= -(DPW'(up_p3[0]) + DPW'(up_p3[1]) + DPW'(up_p3[2]));
			ts_p4  <= ts_p3;
			tf_p4  <= tf_p3;
			dg_p4  <= dg_p3;
			s_p4   <= s_p3;
			f_p4   <= f_p3;
			u_p4   <= u_p3;
		end
	end

	logic                  dg_p5;
	logic signed [UW-1:0]  s_p5 [3];
	logic signed [UW-1:0]  f_p5 [3];
	logic signed [UUW-1:0] u_p5 [3];
	logic signed [DW-1:0]  ts_p5;
	logic signed [DW-1:0]  tu_p5;
	logic signed [DW-1:0]  tf_p5;

	always_ff @(posedge clk) begin
		if (en) begin
			tu_p5 <= rnd_sat(tun_p4);
			ts_p5 <= ts_p4;
			tf_p5 <= tf_p4;
			dg_p5 <= dg_p4;
			s_p5  <= s_p4;
			f_p5  <= f_p4;
			u_p5  <= u_p4;
		end
	end

	logic vld_p2, vld_p3, vld_p4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_p1 <= 1'b0;
			vld_p2 <= 1'b0;
			vld_p3 <= 1'b0;
			vld_p4 <= 1'b0;
			vld_p5 <= 1'b0;
		end else if (en) begin
			vld_p1 <= vld_n2;
			vld_p2 <= vld_p1;
			vld_p3 <= vld_p2;
			vld_p4 <= vld_p3;
			vld_p5 <= vld_p4;
		end
	end

	// output matrix register and row sequencing
	logic                 itm_vld_q;
	row_t                 row_q;
	logic                 dg_q;
	logic signed [DW-1:0] mat_q [3][4];

	assign load     = vld_p5 && (!itm_vld_q || (row_q == ROW_W && !out_stall));
	assign en       = !vld_p5 || load;
	assign in_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			itm_vld_q <= 1'b0;
			row_q     <= ROW_RIGHT;
		end else if (load) begin
			itm_vld_q <= 1'b1;
			row_q     <= ROW_RIGHT;
		end else if (itm_vld_q && !out_stall) begin
			if (row_q == ROW_W)
				itm_vld_q <= 1'b0;
			row_q <= row_t'(2'(row_q + 2'd1));
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			dg_q <= dg_p5;
			if (dg_p5) begin
				mat_q <= '{'{Q_ONE, '0, '0, '0},
				           '{'0, Q_ONE, '0, '0},
				           '{'0, '0, Q_ONE, '0}};
			end else begin
				for (int i = 0; i < 3; i++) begin
					mat_q[0][i] <= DW'(s_p5[i]);
					mat_q[1][i] <= DW'(u_p5[i]);
					mat_q[2][i] <= -DW'(f_p5[i]);
				end
				mat_q[0][3] <= ts_p5;
				mat_q[1][3] <= tu_p5;
				mat_q[2][3] <= tf_p5;
			end
		end
	end

	always_comb begin
		case (row_q)
			ROW_RIGHT: begin
				col0 = mat_q[0][0];
				col1 = mat_q[0][1];
				col2 = mat_q[0][2];
				col3 = mat_q[0][3];
			end
			ROW_UP: begin
				col0 = mat_q[1][0];
				col1 = mat_q[1][1];
				col2 = mat_q[1][2];
				col3 = mat_q[1][3];
			end
			ROW_FWD: begin
				col0 = mat_q[2][0];
				col1 = mat_q[2][1];
				col2 = mat_q[2][2];
				col3 = mat_q[2][3];
			end
			default: begin
				col0 = '0;
				col1 = '0;
				col2 = '0;
				col3 = Q_ONE;
			end
		endcase
	end

	assign out_valid  = itm_vld_q;
	assign row_index  = row_q;
	assign degenerate = dg_q;
	assign last       = (row_q == ROW_W);

endmodule
`default_nettype wire

### dv/lookat_view_matrix_checker.sv
// lookat view matrix checker: watches both channels, predicts the matrix rows and compares
`timescale 1ns / 1ps
module lookat_view_matrix_checker (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	input  wire logic                          in_stall,
	input  wire logic signed [lvm_pkg::DW-1:0] pos_x,
	input  wire logic signed [lvm_pkg::DW-1:0] pos_y,
	input  wire logic signed [lvm_pkg::DW-1:0] pos_z,
	input  wire logic signed [lvm_pkg::DW-1:0] target_x,
	input  wire logic signed [lvm_pkg::DW-1:0] target_y,
	input  wire logic signed [lvm_pkg::DW-1:0] target_z,
	input  wire logic signed [lvm_pkg::DW-1:0] up_x,
	input  wire logic signed [lvm_pkg::DW-1:0] up_y,
	input  wire logic signed [lvm_pkg::DW-1:0] up_z,
	input  wire logic                          out_valid,
	input  wire logic                          out_stall,
	input  wire logic [1:0]                    row_index,
	input  wire logic signed [lvm_pkg::DW-1:0] col0,
	input  wire logic signed [lvm_pkg::DW-1:0] col1,
	input  wire logic signed [lvm_pkg::DW-1:0] col2,
	input  wire logic signed [lvm_pkg::DW-1:0] col3,
	input  wire logic                          degenerate,
	input  wire logic                          last,
	output int                                 fail_count,
	output int                                 rows_pending
);
	import lvm_pkg::*;

	typedef struct packed {
		logic [1:0]  idx;
		logic [31:0] c0, c1, c2, c3;
		logic        dg, lst;
	} row_s;

	row_s matrix_rows[$];

	assign rows_pending = matrix_rows.size();

	function automatic logic [63:0] abs64(input logic signed [63:0] x);
		return x < 0 ? -x : x;
	endfunction

	function automatic logic [63:0] int_sqrt(input logic [63:0] n);
		logic [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b = b >> 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n = n - (r + b);
				r = (r >> 1) + b;
			end else
				r = r >> 1;
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic logic signed [63:0] to_q16(input logic signed [63:0] x);
		logic signed [63:0] t;
		t = x + 64'sd32768;
		return t >>> 16;
	endfunction

	function automatic logic signed [63:0] clamp32(input logic signed [63:0] x);
		if (x > 64'sd2147483647) return 64'sd2147483647;
		if (x < -64'sd2147483648) return -64'sd2147483648;
		return x;
	endfunction

	function automatic bit unit_vec(input logic signed [63:0] v[3],
			output logic signed [63:0] o[3]);
		logic [63:0] a[3], m, sum, len, q;
		m = 0;
		sum = 0;
		for (int i = 0; i < 3; i++) begin
			a[i] = abs64(v[i]);
			if (a[i] > m) m = a[i];
		end
		if (m == 0) return 0;
		while (m >= (64'd1 << 30)) begin
			for (int i = 0; i < 3; i++) a[i] = a[i] >> 1;
			m = m >> 1;
		end
		while (m < (64'd1 << 29)) begin
			for (int i = 0; i < 3; i++) a[i] = a[i] << 1;
			m = m << 1;
		end
		for (int i = 0; i < 3; i++) sum = sum + a[i] * a[i];
		len = int_sqrt(sum);
		for (int i = 0; i < 3; i++) begin
			q = ((a[i] << 16) + (len >> 1)) / len;
			o[i] = v[i] < 0 ? -$signed(q) : $signed(q);
		end
		return 1;
	endfunction

	function automatic row_s mk_row(input int k, input logic signed [63:0] a, b, c, d,
			input bit dg);
		row_s r;
		r.idx = k[1:0];
		r.c0 = a[31:0];
		r.c1 = b[31:0];
		r.c2 = c[31:0];
		r.c3 = d[31:0];
		r.dg = dg;
		r.lst = (k == 3);
		return r;
	endfunction

	task automatic build_view_rows();
		logic signed [63:0] p[3], d[3], w[3], f[3], c[3], s[3], u[3];
		logic signed [63:0] ts, tu, tf;
		bit ok;
		p = '{pos_x, pos_y, pos_z};
		d = '{64'(target_x) - pos_x, 64'(target_y) - pos_y, 64'(target_z) - pos_z};
		w = '{up_x, up_y, up_z};
		ok = unit_vec(d, f);
		if (ok) begin
			c[0] = f[1] * w[2] - f[2] * w[1];
			c[1] = f[2] * w[0] - f[0] * w[2];
			c[2] = f[0] * w[1] - f[1] * w[0];
			ok = unit_vec(c, s);
		end
		if (!ok) begin
			matrix_rows.push_back(mk_row(ROW_RIGHT, 65536, 0, 0, 0, 1));
			matrix_rows.push_back(mk_row(ROW_UP, 0, 65536, 0, 0, 1));
			matrix_rows.push_back(mk_row(ROW_FWD, 0, 0, 65536, 0, 1));
			matrix_rows.push_back(mk_row(ROW_W, 0, 0, 0, 65536, 1));
			return;
		end
		u[0] = to_q16(s[1] * f[2] - s[2] * f[1]);
		u[1] = to_q16(s[2] * f[0] - s[0] * f[2]);
		u[2] = to_q16(s[0] * f[1] - s[1] * f[0]);
		ts = clamp32(to_q16(-(s[0] * p[0] + s[1] * p[1] + s[2] * p[2])));
		tu = clamp32(to_q16(-(u[0] * p[0] + u[1] * p[1] + u[2] * p[2])));
		tf = clamp32(to_q16(f[0] * p[0] + f[1] * p[1] + f[2] * p[2]));
		matrix_rows.push_back(mk_row(ROW_RIGHT, s[0], s[1], s[2], ts, 0));
		matrix_rows.push_back(mk_row(ROW_UP, u[0], u[1], u[2], tu, 0));
		matrix_rows.push_back(mk_row(ROW_FWD, -f[0], -f[1], -f[2], tf, 0));
		matrix_rows.push_back(mk_row(ROW_W, 0, 0, 0, 65536, 0));
	endtask

	task automatic note_fail(input string what, input row_s e, input row_s a);
		fail_count++;
		if (fail_count <= 10)
			$display("row mismatch (%s) exp idx=%0d %h %h %h %h dg=%b l=%b got idx=%0d %h %h %h %h dg=%b l=%b",
				what, e.idx, e.c0, e.c1, e.c2, e.c3, e.dg, e.lst,
				a.idx, a.c0, a.c1, a.c2, a.c3, a.dg, a.lst);
	endtask

	initial fail_count = 0;

	always @(posedge clk) begin
		row_s got, want;
		if (arst_n) begin
			if (in_valid && !in_stall)
				build_view_rows();
			if (out_valid && !out_stall) begin
				got = '{row_index, col0, col1, col2, col3, degenerate, last};
				if (matrix_rows.size() == 0)
					note_fail("unexpected", '0, got);
				else begin
					want = matrix_rows.pop_front();
					if (got !== want)
						note_fail("fields", want, got);
				end
			end
		end
	end

endmodule

### dv/lookat_view_matrix_tb.sv
// lookat view matrix testbench top: clock, reset, camera requests, receiver stalls and verdict
`timescale 1ns / 1ps
module lookat_view_matrix_tb;
	import lvm_pkg::*;

	localparam int N_RAND = 70;
	localparam int N_FILL = 90;
	localparam int LIMIT = 400000;

	logic clk = 0, arst_n = 0;
	logic in_valid = 0, in_stall, out_valid, out_stall = 0;
	logic signed [DW-1:0] pos_x = 0, pos_y = 0, pos_z = 0;
	logic signed [DW-1:0] target_x = 0, target_y = 0, target_z = 0;
	logic signed [DW-1:0] up_x = 0, up_y = 0, up_z = 0;
	logic [1:0] row_index;
	logic signed [DW-1:0] col0, col1, col2, col3;
	logic degenerate, last;
	int fail_count, rows_pending, cycles = 0;
	bit calm = 0, hold_off = 0;

	lookat_view_matrix u_dut (.*);
	lookat_view_matrix_checker u_chk (.*);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (hold_off)
			out_stall <= 1;
		else
			out_stall <= calm ? 0 : ($urandom_range(99) < 21);
	end

	function automatic logic signed [31:0] rnd_coord(input int mode);
		case (mode)
			0: return $urandom;
			1: return $signed($urandom_range(0, 40 << 16)) - (20 << 16);
			2: return $signed($urandom_range(0, 1 << 13)) - (1 << 12);
			default: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
		endcase
	endfunction

	// valid stays up between back-to-back requests and drops only while idling
	task automatic send(input logic signed [31:0] v[9]);
		if (!calm)
			while ($urandom_range(99) < 21) begin
				in_valid <= 0;
				@(posedge clk);
			end
		{pos_x, pos_y, pos_z} <= {v[0], v[1], v[2]};
		{target_x, target_y, target_z} <= {v[3], v[4], v[5]};
		{up_x, up_y, up_z} <= {v[6], v[7], v[8]};
		in_valid <= 1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	initial begin
		logic signed [31:0] v[9];
		int mode;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// typical camera, y up
		send('{0, 0, 5 << 16, 0, 0, 0, 0, 1 << 16, 0});
		send('{3 << 16, 2 << 16, -7 << 16, 1 << 16, -1 << 16, 4 << 16, 0, 1 << 16, 0});
		// target equals position
		send('{7 << 16, 7 << 16, 7 << 16, 7 << 16, 7 << 16, 7 << 16, 0, 1 << 16, 0});
		// zero up
		send('{0, 0, 0, 1 << 16, 0, 0, 0, 0, 0});
		// up parallel to forward
		send('{0, 0, 0, 0, 2 << 16, 0, 0, 5 << 16, 0});
		// extremes
		send('{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
			32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff});
		send('{32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff,
			32'sh7fffffff, 32'sh80000000, 0, 32'sh7fffffff});
		send('{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
			32'sh7ffffffe, -1, 1, -1});
		send('{-1, -1, -1, 0, 0, 0, 1, 0, 0});
		send('{32'sh12345678, -32'sh2468ace, 32'sh0, 1, 0, 0, 0, 0, 1});
		send('{32'sh7fff0000, 32'sh7fff0000, 32'sh7fff0000, 32'sh80010000, 0, 0, 0, 1 << 16, 1});
		// fill the pipe while the receiver holds off
		hold_off = 1;
		fork
			repeat (300) @(posedge clk);
			begin
				for (int i = 0; i < N_FILL; i++) begin
					for (int j = 0; j < 9; j++) v[j] = rnd_coord(1);
					send(v);
				end
				in_valid <= 0;
				@(posedge clk);
			end
		join_any
		hold_off = 0;
		wait fork;
		for (int i = 0; i < N_RAND; i++) begin
			calm = (i >= 20 && i < 50);
			mode = $urandom_range(0, 9);
			for (int j = 0; j < 9; j++)
				v[j] = rnd_coord(mode < 4 ? 1 : mode < 7 ? 0 : mode < 9 ? 2 : 3);
			if ($urandom_range(0, 19) == 0) v[3:5] = v[0:2];
			if ($urandom_range(0, 19) == 0) v[6:8] = '{0, 0, 0};
			send(v);
		end
		in_valid <= 0;
		calm = 0;
		while (rows_pending != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
